// File: src/ash_pkg.sv
// Shared constants, command/status types and binning functions for the histogram unit.
package ash_pkg;

    localparam int NBINS = 11;
    localparam int BIN_W = 4;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_LIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOG2  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOG10 = 2'd2;

    localparam logic [BIN_W-1:0] BIN_LAST = 4'd10;

    localparam logic [31:0] POW10 [10] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    localparam logic [31:0] LOG_MAX_MIN   = 32'd16;
    localparam logic [31:0] LOG10_MAX_MIN = 32'd1000000;
    localparam logic [9:0]  LOG10_MEAN    = 10'd1000;

    typedef struct packed {
        logic             load;
        logic             mul;
        logic             test;
        logic             sweep;
        logic             copy;
        logic             binup;
        logic             respond;
        logic [BIN_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic in_acc;
        logic rescale;
        logic out_busy;
    } status_t;

    // Bin of a value under the given scale, capped at the last bin.
    function automatic logic [BIN_W-1:0] val_to_bin(logic [MODE_W-1:0] mode, logic [31:0] v);
        logic [31:0]      vm1;
        logic [BIN_W-1:0] b;
        vm1 = v - 32'd1;
        b = BIN_LAST;
        if (v <= 32'd1) begin
            b = v[BIN_W-1:0];
        end else if (mode == MODE_LOG10) begin
            for (int k = 9; k >= 0; k--) begin
                if (v <= POW10[k]) begin
                    b = BIN_W'(k);
                end
            end
        end else if (mode == MODE_LOG2) begin
            if (vm1[31:10] == 22'd0) begin
                b = '0;
                for (int i = 0; i < 10; i++) begin
                    if (vm1[i]) begin
                        b = BIN_W'(i + 1);
                    end
                end
            end
        end else begin
            if (v <= 32'(BIN_LAST)) begin
                b = v[BIN_W-1:0];
            end
        end
        return b;
    endfunction

    // Lower label of a bin under the given scale.
    function automatic logic [31:0] bin_to_val(logic [MODE_W-1:0] mode, logic [BIN_W-1:0] b);
        logic [BIN_W-1:0] bm1;
        logic [31:0]      v;
        bm1 = b - 4'd1;
        if (b <= 4'd1 || mode == MODE_LIN) begin
            v = 32'(b);
        end else if (mode == MODE_LOG2) begin
            v = 32'd1 << bm1;
        end else begin
            v = POW10[(bm1 > 4'd9) ? 4'd9 : bm1];
        end
        return v;
    endfunction

endpackage

// File: src/ash_ctrl.sv
// Sequencer for the histogram unit: steps each word through update, test, rebin and reply as needed.
module ash_ctrl
    import ash_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output cmd_t    cmd,
    input  status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_TEST  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_COPY  = 3'd4;
    localparam logic [2:0] ST_BINUP = 3'd5;
    localparam logic [2:0] ST_RESP  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [BIN_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.in_acc ? ST_MUL : ST_BINUP;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                cmd.test  = 1'b1;
                step_next = '0;
                state_next = status.rescale ? ST_SWEEP : ST_BINUP;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                step_next = step_reg + 4'd1;
                if (step_reg == BIN_LAST) begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                cmd.copy   = 1'b1;
                state_next = ST_BINUP;
            end
            ST_BINUP:
            begin
                cmd.binup  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // hold until the output register is free
                if (!status.out_busy) begin
                    cmd.respond = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: src/ash_dp.sv
// Datapath of the histogram unit: statistics, scale test, bins, rebin sweep and output word.
module ash_dp
    import ash_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              func,
    input  logic [31:0]       sample,
    input  logic [BIN_W-1:0]  read_bin,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BIN_W-1:0]  sample_bin,
    output logic [MODE_W-1:0] scale_mode,
    output logic              rescaled,
    output logic [31:0]       sample_count,
    output logic [31:0]       max_sample,
    output logic [63:0]       sample_sum,
    output logic [63:0]       square_sum,
    output logic [31:0]       bin_count,
    input  cmd_t              cmd,
    output status_t           status
);

    // architectural state
    logic [31:0]       count_reg;
    logic [31:0]       max_reg;
    logic [63:0]       sum_reg;
    logic [63:0]       square_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [31:0]       bins_reg [NBINS];
    logic [31:0]       merged_reg [NBINS];

    // per-word working registers
    logic              func_reg;
    logic [31:0]       sample_reg;
    logic [BIN_W-1:0]  read_bin_reg;
    logic [63:0]       prod_reg;
    logic [41:0]       kcount_reg;
    logic [MODE_W-1:0] nm_reg;
    logic              rescaled_reg;
    logic [BIN_W-1:0]  sb_reg;

    // output word
    logic              out_valid_reg;
    logic [BIN_W-1:0]  o_bin_reg;
    logic [MODE_W-1:0] o_mode_reg;
    logic              o_rescaled_reg;
    logic [31:0]       o_count_reg;
    logic [31:0]       o_max_reg;
    logic [63:0]       o_sum_reg;
    logic [63:0]       o_square_reg;
    logic [31:0]       o_bin_count_reg;

    logic [64:0]       sum_add;
    logic [64:0]       sq_add;
    logic              grow_ok;
    logic              deca_ok;
    logic [MODE_W-1:0] nm;
    logic [BIN_W-1:0]  sweep_nb;
    logic [BIN_W-1:0]  sb;
    logic [31:0]       rb_count;

    assign sum_add = {1'b0, sum_reg} + {33'd0, sample};
    assign sq_add  = {1'b0, square_reg} + {1'b0, prod_reg};

    assign grow_ok = (mode_reg != MODE_LOG10) && (max_reg > LOG_MAX_MIN) &&
                     (sum_reg > {29'd0, count_reg, 3'b000});
    assign deca_ok = (max_reg > LOG10_MAX_MIN) && (sum_reg > {22'd0, kcount_reg});
    assign nm      = deca_ok ? MODE_LOG10 : MODE_LOG2;

    assign status.in_acc   = ~func;
    assign status.rescale  = grow_ok && (nm != mode_reg);
    assign status.out_busy = out_valid_reg && out_stall;

    assign sweep_nb = val_to_bin(nm_reg, bin_to_val(mode_reg, cmd.step));
    assign sb       = val_to_bin(mode_reg, sample_reg);
    assign rb_count = (read_bin_reg < BIN_W'(NBINS)) ? bins_reg[read_bin_reg] : 32'd0;

    // statistics and mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg  <= '0;
            max_reg    <= '0;
            sum_reg    <= '0;
            square_reg <= '0;
            mode_reg   <= MODE_LIN;
        end else begin
            if (cmd.load && !func) begin
                count_reg <= (count_reg == '1) ? count_reg : count_reg + 32'd1;
                if (sample > max_reg) begin
                    max_reg <= sample;
                end
                sum_reg <= sum_add[64] ? '1 : sum_add[63:0];
            end
            if (cmd.test) begin
                square_reg <= sq_add[64] ? '1 : sq_add[63:0];
            end
            if (cmd.copy) begin
                mode_reg <= nm_reg;
            end
        end
    end

    // histogram bins: rotate during the sweep, reload from the merge, count the sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NBINS; i++) begin
                bins_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NBINS; i++) begin
                priority if (cmd.copy) begin
                    bins_reg[i] <= merged_reg[i];
                end else if (cmd.sweep) begin
                    bins_reg[i] <= bins_reg[(i + 1) % NBINS];
                end else if (cmd.binup && !func_reg && sb == BIN_W'(i)) begin
                    if (bins_reg[i] != '1) begin
                        bins_reg[i] <= bins_reg[i] + 32'd1;
                    end
                end else begin
                    bins_reg[i] <= bins_reg[i];
                end
            end
        end
    end

    // merge targets: clear at the test, accumulate the head bin each sweep step
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NBINS; i++) begin
            if (cmd.test) begin
                merged_reg[i] <= '0;
            end else if (cmd.sweep && sweep_nb == BIN_W'(i)) begin
                merged_reg[i] <= (merged_reg[i] + bins_reg[0] < merged_reg[i]) ?
                                 '1 : merged_reg[i] + bins_reg[0];
            end
        end
    end

    // per-word working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            func_reg     <= func;
            sample_reg   <= sample;
            read_bin_reg <= read_bin;
        end
        if (cmd.mul) begin
            prod_reg   <= sample_reg * sample_reg;
            kcount_reg <= count_reg * LOG10_MEAN;
        end
        if (cmd.test) begin
            nm_reg <= nm;
        end
        if (cmd.binup) begin
            sb_reg <= sb;
        end
        if (cmd.load) begin
            rescaled_reg <= 1'b0;
        end else if (cmd.copy) begin
            rescaled_reg <= 1'b1;
        end
    end

    // output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.respond) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond) begin
            o_bin_reg       <= sb_reg;
            o_mode_reg      <= mode_reg;
            o_rescaled_reg  <= rescaled_reg;
            o_count_reg     <= count_reg;
            o_max_reg       <= max_reg;
            o_sum_reg       <= sum_reg;
            o_square_reg    <= square_reg;
            o_bin_count_reg <= rb_count;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_bin   = o_bin_reg;
    assign scale_mode   = o_mode_reg;
    assign rescaled     = o_rescaled_reg;
    assign sample_count = o_count_reg;
    assign max_sample   = o_max_reg;
    assign sample_sum   = o_sum_reg;
    assign square_sum   = o_square_reg;
    assign bin_count    = o_bin_count_reg;

endmodule

// File: src/adaptive_scale_histogram.sv
// Top level of the adaptive-scale histogram unit: sequencer plus datapath.
//
// Input channel: in_valid/in_stall with func, sample and read_bin. A word is
// taken when in_valid is high and in_stall low. func 0 folds the sample into
// count, max, sum, sum of squares and the histogram; func 1 only reports.
// Output channel: out_valid/out_stall, one result word per input word, held
// in an output register so the next input word can be taken while it waits.
// Steps per word, taken by the sequencer one word at a time:
//   report only: accept, bin, reply.
//   accumulate: accept, square multiply, scale test, bin, reply.
//   accumulate that changes scale: as accumulate, but after the scale test
//   the eleven bins are swept one per cycle and then reloaded.
// The result appears in the output register the cycle after the reply step.
// A scale change happens at most twice after reset.
// Reset (rst_n low, asynchronous) clears all statistics and bins, selects
// linear bins and drops any pending output word.
// While the receiver stalls, the result word holds; a word finished behind
// it waits in the reply step and stalls the input.
module adaptive_scale_histogram
    import ash_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [31:0]       sample,
    input  logic [BIN_W-1:0]  read_bin,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BIN_W-1:0]  sample_bin,
    output logic [MODE_W-1:0] scale_mode,
    output logic              rescaled,
    output logic [31:0]       sample_count,
    output logic [31:0]       max_sample,
    output logic [63:0]       sample_sum,
    output logic [63:0]       square_sum,
    output logic [31:0]       bin_count
);

    cmd_t    cmd;
    status_t status;

    // sequencer: owns the input handshake and the rebin step count
    ash_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath: statistics, bins and the output register
    ash_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (func),
        .sample       (sample),
        .read_bin     (read_bin),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_bin   (sample_bin),
        .scale_mode   (scale_mode),
        .rescaled     (rescaled),
        .sample_count (sample_count),
        .max_sample   (max_sample),
        .sample_sum   (sample_sum),
        .square_sum   (square_sum),
        .bin_count    (bin_count),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// File: bench/tb.sv
// Self-checking bench for adaptive_scale_histogram: bursty driver, stalling monitor, scoreboard.
module tb
    import ash_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Word operations on the input channel.
    localparam logic FUNC_ACC  = 1'b0;   // fold sample in, then report
    localparam logic FUNC_PEEK = 1'b1;   // report only, state untouched

    // Thresholds of the scale switch.
    localparam logic [31:0] PEAK_FOR_LOG2  = 32'd16;
    localparam logic [63:0] MEAN_FOR_LOG2  = 64'd8;
    localparam logic [31:0] PEAK_FOR_LOG10 = 32'd1000000;
    localparam logic [63:0] MEAN_FOR_LOG10 = 64'd1000;

    // Random stimulus length per scale stage: linear, log2, log10.
    localparam int STAGE_WORDS [3] = '{250, 250, 300};
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic             op;
        logic [31:0]      value;
        logic [BIN_W-1:0] slot;
    } word_t;

    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [MODE_W-1:0] mode;
        logic              flip;
        logic [31:0]       count;
        logic [31:0]       peak;
        logic [63:0]       total;
        logic [63:0]       squares;
        logic [31:0]       hits;
    } report_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              func = FUNC_PEEK;
    logic [31:0]       sample = '0;
    logic [BIN_W-1:0]  read_bin = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BIN_W-1:0]  sample_bin;
    logic [MODE_W-1:0] scale_mode;
    logic              rescaled;
    logic [31:0]       sample_count;
    logic [31:0]       max_sample;
    logic [63:0]       sample_sum;
    logic [63:0]       square_sum;
    logic [31:0]       bin_count;

    adaptive_scale_histogram u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .sample       (sample),
        .read_bin     (read_bin),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_bin   (sample_bin),
        .scale_mode   (scale_mode),
        .rescaled     (rescaled),
        .sample_count (sample_count),
        .max_sample   (max_sample),
        .sample_sum   (sample_sum),
        .square_sum   (square_sum),
        .bin_count    (bin_count)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow statistics of the block, advanced once per accepted word.
    // ------------------------------------------------------------------
    logic [31:0]       tally;
    logic [31:0]       peak;
    logic [63:0]       total;
    logic [63:0]       squares;
    logic [MODE_W-1:0] scale;
    logic [31:0]       hist [NBINS];

    word_t   sample_words [$];   // words still to be sent
    report_t due_reports [$];    // predicted result words, oldest first
    int      words_total;
    int      words_taken;
    int      mismatches;

    function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Bin index of a value under a scale; 0 and 1 map to themselves, cap at 10.
    function automatic logic [BIN_W-1:0] bin_for(logic [MODE_W-1:0] m, logic [31:0] v);
        logic [31:0] x;
        logic [63:0] p;
        int          n;
        n = 0;
        if (v <= 32'd1)
        begin
            n = int'(v[0]);
        end
        else if (m == MODE_LOG10)
        begin
            // smallest power of ten not below v
            p = 64'd1;
            while (p < {32'd0, v} && n < 10)
            begin
                p = p * 64'd10;
                n++;
            end
        end
        else if (m == MODE_LOG2)
        begin
            // ceiling log2 is the bit length of v-1
            x = v - 32'd1;
            while (x != 32'd0)
            begin
                n++;
                x = x >> 1;
            end
        end
        else
        begin
            n = (v > 32'd10) ? 10 : int'(v[3:0]);
        end
        if (n > 10)
        begin
            n = 10;
        end
        return BIN_W'(n);
    endfunction

    // Lowest value that a bin stands for under a scale.
    function automatic logic [31:0] label_of(logic [MODE_W-1:0] m, logic [BIN_W-1:0] b);
        logic [31:0] p;
        p = 32'd1;
        if (b <= 4'd1 || m == MODE_LIN)
        begin
            return 32'(b);
        end
        if (m == MODE_LOG2)
        begin
            return 32'd1 << (b - 4'd1);
        end
        for (int i = 1; i < int'(b); i++)
        begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    // Advance the shadow statistics by one word and queue the report it yields.
    task automatic histogram_step(input word_t w);
        logic [MODE_W-1:0] target;
        logic [31:0]       merged [NBINS];
        logic [BIN_W-1:0]  nb;
        report_t           r;
        r.flip = 1'b0;
        if (w.op == FUNC_ACC)
        begin
            tally   = add_sat32(tally, 32'd1);
            peak    = (w.value > peak) ? w.value : peak;
            total   = add_sat64(total, 64'(w.value));
            squares = add_sat64(squares, 64'(w.value) * 64'(w.value));
            if (scale != MODE_LOG10 && peak > PEAK_FOR_LOG2
                && total > MEAN_FOR_LOG2 * 64'(tally))
            begin
                target = (peak > PEAK_FOR_LOG10 && total > MEAN_FOR_LOG10 * 64'(tally))
                         ? MODE_LOG10 : MODE_LOG2;
                if (target != scale)
                begin
                    // rebin each old bin by its lower label, merging counts
                    for (int b = 0; b < NBINS; b++)
                    begin
                        merged[b] = '0;
                    end
                    for (int b = 0; b < NBINS; b++)
                    begin
                        nb = bin_for(target, label_of(scale, BIN_W'(b)));
                        merged[nb] = add_sat32(merged[nb], hist[b]);
                    end
                    hist   = merged;
                    scale  = target;
                    r.flip = 1'b1;
                end
            end
            r.bin = bin_for(scale, w.value);
            hist[r.bin] = add_sat32(hist[r.bin], 32'd1);
        end
        else
        begin
            r.bin = bin_for(scale, w.value);
        end
        r.mode    = scale;
        r.count   = tally;
        r.peak    = peak;
        r.total   = total;
        r.squares = squares;
        r.hits    = (w.slot < BIN_W'(NBINS)) ? hist[w.slot] : '0;
        due_reports.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Driver: send words in bursts of random length with random gaps.
    // A word is taken on the edge where in_valid is high and in_stall low.
    // ------------------------------------------------------------------
    int    burst_left;
    int    gap_left;
    word_t next_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= FUNC_PEEK;
            sample     <= '0;
            read_bin   <= '0;
            burst_left = 0;
            gap_left   = 0;
            tally      = '0;
            peak       = '0;
            total      = '0;
            squares    = '0;
            scale      = MODE_LIN;
            for (int b = 0; b < NBINS; b++)
            begin
                hist[b] = '0;
            end
        end
        else
        begin
            // Predict from the word on the pins before this edge.
            if (in_valid && !in_stall)
            begin
                histogram_step('{op: func, value: sample, slot: read_bin});
                words_taken++;
            end
            // Hold a stalled word; otherwise advance to a new word or idle.
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0 || sample_words.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                    begin
                        gap_left--;
                    end
                end
                else
                begin
                    next_word = sample_words.pop_front();
                    in_valid <= 1'b1;
                    func     <= next_word.op;
                    sample   <= next_word.value;
                    read_bin <= next_word.slot;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    if (burst_left == 0)
                    begin
                        // now and then a long stretch with no idling at all
                        burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every result word against the oldest prediction,
    // and drive out_stall from a pattern that changes style now and then.
    // ------------------------------------------------------------------
    int      stall_style;
    int      style_left;
    report_t want;

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t MISMATCH %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_style = 0;
            style_left  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_reports.size() == 0)
                begin
                    $display("%0t MISMATCH unexpected result word, expected none, actual bin %0d",
                             $realtime, sample_bin);
                    mismatches++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    check_field("sample_bin",   64'(want.bin),   64'(sample_bin));
                    check_field("scale_mode",   64'(want.mode),  64'(scale_mode));
                    check_field("rescaled",     64'(want.flip),  64'(rescaled));
                    check_field("sample_count", 64'(want.count), 64'(sample_count));
                    check_field("max_sample",   64'(want.peak),  64'(max_sample));
                    check_field("sample_sum",   want.total,      sample_sum);
                    check_field("square_sum",   want.squares,    square_sum);
                    check_field("bin_count",    64'(want.hits),  64'(bin_count));
                end
            end
            // Pick a new stall style when the current style has run its course.
            if (style_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(20, 150);
            end
            style_left--;
            case (stall_style)
                0:       out_stall <= 1'b0;                          // drain freely
                1:       out_stall <= ($urandom_range(0, 99) < 30);  // light stalls
                2:       out_stall <= ($urandom_range(0, 99) < 75);  // heavy stalls
                default: out_stall <= ((style_left % 9) < 5);        // periodic blocks
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    task automatic add_word(input logic op, input logic [31:0] value,
                            input logic [BIN_W-1:0] slot);
        sample_words.push_back('{op: op, value: value, slot: slot});
    endtask

    initial
    begin
        logic [31:0] v;
        logic        op;
        int          k;

        words_taken = 0;
        mismatches  = 0;

        // Directed part, all in linear scale: report-only words at the
        // field extremes, then every linear bin, then a peak above 16
        // while the mean stays low so the scale must not switch.
        add_word(FUNC_PEEK, 32'd0,          4'd0);
        add_word(FUNC_PEEK, 32'hFFFF_FFFF,  4'd15);
        add_word(FUNC_PEEK, 32'd1,          4'd11);
        add_word(FUNC_PEEK, 32'hAAAA_AAAA,  4'd10);
        add_word(FUNC_PEEK, 32'h5555_5555,  4'd5);
        for (int i = 0; i <= 10; i++)
        begin
            add_word(FUNC_ACC, 32'(i), BIN_W'(i));
        end
        add_word(FUNC_ACC,  32'd11, 4'd10);
        add_word(FUNC_ACC,  32'd17, 4'd10);
        add_word(FUNC_ACC,  32'd0,  4'd0);
        add_word(FUNC_PEEK, 32'd20, 4'd12);
        add_word(FUNC_PEEK, 32'd2,  4'd2);
        add_word(FUNC_ACC,  32'd1,  4'd1);

        // Random part in three stages that walk the scale upward:
        // low values keep it linear, values into the thousands push it to
        // log2, and full-range values push it to log10.
        for (int stage = 0; stage < 3; stage++)
        begin
            for (int n = 0; n < STAGE_WORDS[stage]; n++)
            begin
                op = ($urandom_range(0, 99) < 20) ? FUNC_PEEK : FUNC_ACC;
                k  = $urandom_range(0, 99);
                if (op == FUNC_PEEK && k < 30)
                begin
                    v = $urandom;
                end
                else if (stage == 0)
                begin
                    v = (k < 90) ? $urandom_range(0, 9) : $urandom_range(10, 30);
                end
                else if (stage == 1)
                begin
                    if (k < 50)
                    begin
                        v = $urandom_range(0, 2100);
                    end
                    else if (k < 75)
                    begin
                        v = $urandom_range(0, 20);
                    end
                    else
                    begin
                        // hit the edges of the power-of-two bins
                        v = (32'd1 << $urandom_range(0, 11)) + 32'($urandom_range(0, 2)) - 32'd1;
                    end
                end
                else
                begin
                    if (k < 40)
                    begin
                        v = $urandom;
                    end
                    else if (k < 70)
                    begin
                        // hit the edges of the power-of-ten bins
                        v = 32'd1;
                        for (int j = $urandom_range(0, 9); j > 0; j--)
                        begin
                            v = v * 32'd10;
                        end
                        v = v + 32'($urandom_range(0, 2)) - 32'd1;
                    end
                    else
                    begin
                        v = $urandom_range(0, 2000);
                    end
                end
                add_word(op, v, BIN_W'($urandom_range(0, 15)));
            end
        end
        words_total = sample_words.size();

        // Hold reset at the start, then release it once.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every word is taken and every report is back,
        // then leave room for a stray extra result word to show up.
        while (words_taken != words_total)
        begin
            @(posedge clk);
        end
        while (due_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5ms;
        $display("tb failed");
        $finish;
    end

endmodule
